// File: design/rfp_pkg.sv
// Shared types, constants and the CRC-8 step for the remote frame parser.
package rfp_pkg;

  localparam logic [7:0] HdrFirst   = 8'hAA;
  localparam logic [7:0] HdrSecond  = 8'h55;
  localparam logic [7:0] CrcPoly    = 8'h07;
  localparam logic [7:0] StickLimit = 8'd100;
  localparam logic [7:0] GearMax    = 8'd2;

  // Frame byte positions
  localparam logic [3:0] PosHdr0    = 4'd0;
  localparam logic [3:0] PosHdr1    = 4'd1;
  localparam logic [3:0] PosVersion = 4'd2;
  localparam logic [3:0] PosLastCrc = 4'd10;
  localparam logic [3:0] PosCrc     = 4'd11;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgVersion = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgTimeout = 1'b1;

  localparam logic [7:0]  VersionRst = 8'd1;
  localparam logic [31:0] TimeoutRst = 32'd100;

  typedef enum logic {
    CmdByte    = 1'b0,
    CmdLineErr = 1'b1
  } rfp_cmd_e;

  typedef struct packed {
    logic        command;
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;
  } rfp_in_t;

  typedef struct packed {
    logic [7:0]        sequence_res;
    logic              pwr_flag;
    logic signed [7:0] left_x;
    logic signed [7:0] left_y;
    logic signed [7:0] right_x;
    logic signed [7:0] right_y;
    logic [1:0]        gear_left;
    logic [1:0]        gear_right;
  } rfp_ctrl_t;

  typedef struct packed {
    logic        frame_accepted;
    rfp_ctrl_t   ctrl;
    logic [31:0] valid_frames;
    logic [31:0] crc_errors;
    logic        online;
  } rfp_res_t;

  // Verdict on a completed frame
  typedef struct packed {
    logic crc_err;
    logic pass;
  } rfp_chk_t;

  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: design/rfp_if.sv
// Valid/ready channel interfaces for the remote frame parser.
interface rfp_in_if import rfp_pkg::*; ();
  logic    valid;
  logic    ready;
  rfp_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rfp_res_if import rfp_pkg::*; ();
  logic     valid;
  logic     ready;
  rfp_res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rfp_cfg_if import rfp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [31:0]        wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

// File: design/rfp_frame_check.sv
// Field checks on a completed frame: version, CRC, power, stick and gear ranges.
module rfp_frame_check import rfp_pkg::*; (
  input  logic [7:0] version_i,
  input  logic [7:0] cfg_version_i,
  input  logic [7:0] crc_calc_i,
  input  logic [7:0] crc_rx_i,
  input  logic [7:0] power_i,
  input  logic [7:0] stick_i [4],
  input  logic [7:0] lgear_i,
  input  logic [7:0] rgear_i,
  output rfp_chk_t   chk_o
);

  logic ver_ok, crc_ok, power_ok, sticks_ok, gears_ok, zero_ok;

  always_comb begin
    ver_ok    = (version_i == cfg_version_i);
    crc_ok    = (crc_calc_i == crc_rx_i);
    power_ok  = (power_i[7:1] == 7'd0);
    sticks_ok = 1'b1;
    zero_ok   = (lgear_i == 8'd0) && (rgear_i == 8'd0);
    for (int i = 0; i < 4; i++) begin
      if (($signed(stick_i[i]) < -$signed(StickLimit)) ||
          ($signed(stick_i[i]) > $signed(StickLimit))) begin
        sticks_ok = 1'b0;
      end
      if (stick_i[i] != 8'd0) begin
        zero_ok = 1'b0;
      end
    end
    gears_ok = (lgear_i != 8'd0) && (lgear_i <= GearMax) &&
               (rgear_i != 8'd0) && (rgear_i <= GearMax);

    chk_o.crc_err = ver_ok && !crc_ok;
    chk_o.pass    = ver_ok && crc_ok && power_ok && sticks_ok &&
                    (power_i[0] ? gears_ok : zero_ok);
  end

endmodule

// File: design/remote_frame_parser_crc8.sv
// Top level of the remote frame parser with CRC-8 frame check.
// Takes one received UART byte or line-error event per cycle while ready, and returns one
// result per item: the held controls of the last valid frame, the valid-frame and CRC-error
// counters and the online flag. The parser hunts for the AA 55 header, collects a 12-byte
// frame and checks version, CRC-8 (poly 0x07, init 0 over bytes 2..10) and field ranges on
// the last byte. The whole per-byte step is a single pass of logic from the parser state
// into a two-entry result buffer, so each result is registered there, and the input keeps
// taking one item per cycle until both result entries are held. Configuration writes are
// registered and always accepted.
module remote_frame_parser_crc8 import rfp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  rfp_in_if.sink    rx_i,
  rfp_res_if.source res_o,
  rfp_cfg_if.sink   cfg_i
);

  logic [7:0]  version_q;
  logic [31:0] timeout_q;

  logic [3:0]  pos_q, pos_d;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  frame_q [PosVersion:PosLastCrc];
  rfp_ctrl_t   held_q, held_d;
  logic [31:0] last_q, last_d;
  logic [31:0] vcnt_q, vcnt_d;
  logic [31:0] ecnt_q, ecnt_d;

  rfp_res_t    main_q, skid_q, res_d;
  logic        main_valid_q, skid_valid_q;

  logic        in_xfer, out_xfer, store_en;
  logic [7:0]  b;
  logic [31:0] age;
  logic [7:0]  sticks [4];
  rfp_chk_t    chk;

  assign in_xfer   = rx_i.valid && rx_i.ready;
  assign out_xfer  = res_o.valid && res_o.ready;
  assign rx_i.ready = !skid_valid_q;
  assign res_o.valid = main_valid_q;
  assign res_o.data  = main_q;
  assign cfg_i.ready = 1'b1;
  assign b = rx_i.data.rx_byte;

  assign sticks[0] = frame_q[5];
  assign sticks[1] = frame_q[6];
  assign sticks[2] = frame_q[7];
  assign sticks[3] = frame_q[8];

  rfp_frame_check u_check (
    .version_i     (frame_q[PosVersion]),
    .cfg_version_i (version_q),
    .crc_calc_i    (crc_q),
    .crc_rx_i      (b),
    .power_i       (frame_q[4]),
    .stick_i       (sticks),
    .lgear_i       (frame_q[9]),
    .rgear_i       (frame_q[10]),
    .chk_o         (chk)
  );

  always_comb begin
    pos_d    = pos_q;
    crc_d    = crc_q;
    held_d   = held_q;
    last_d   = last_q;
    vcnt_d   = vcnt_q;
    ecnt_d   = ecnt_q;
    store_en = 1'b0;
    res_d.frame_accepted = 1'b0;

    if (rx_i.data.command == CmdLineErr) begin
      pos_d = PosHdr0;
    end else begin
      case (pos_q)
        PosHdr0: begin
          if (b == HdrFirst) pos_d = PosHdr1;
        end
        PosHdr1: begin
          if (b == HdrSecond) begin
            pos_d = PosVersion;
          end else if (b != HdrFirst) begin
            pos_d = PosHdr0;
          end
        end
        default: begin
          store_en = (pos_q <= PosLastCrc);
          if (pos_q == PosVersion) begin
            crc_d = crc8_feed(8'd0, b);
          end else if (pos_q <= PosLastCrc) begin
            crc_d = crc8_feed(crc_q, b);
          end
          if (pos_q >= PosCrc) begin
            pos_d = PosHdr0;
            if (chk.crc_err) ecnt_d = ecnt_q + 32'd1;
            if (chk.pass) begin
              held_d.sequence_res = frame_q[3];
              held_d.pwr_flag     = frame_q[4][0];
              held_d.left_x       = frame_q[5];
              held_d.left_y       = frame_q[6];
              held_d.right_x      = frame_q[7];
              held_d.right_y      = frame_q[8];
              held_d.gear_left    = frame_q[9][1:0];
              held_d.gear_right   = frame_q[10][1:0];
              last_d = rx_i.data.now_ms;
              vcnt_d = vcnt_q + 32'd1;
              res_d.frame_accepted = 1'b1;
            end
          end else begin
            pos_d = pos_q + 4'd1;
          end
        end
      endcase
    end

    age = rx_i.data.now_ms - last_d;
    res_d.ctrl         = held_d;
    res_d.valid_frames = vcnt_d;
    res_d.crc_errors   = ecnt_d;
    res_d.online       = (vcnt_d != 32'd0) && (age <= timeout_q);
  end

  // Parser state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= VersionRst;
      timeout_q <= TimeoutRst;
      pos_q     <= PosHdr0;
      crc_q     <= 8'd0;
      held_q    <= '0;
      last_q    <= 32'd0;
      vcnt_q    <= 32'd0;
      ecnt_q    <= 32'd0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CfgVersion: version_q <= cfg_i.wdata[7:0];
          CfgTimeout: timeout_q <= cfg_i.wdata;
          default: ;
        endcase
      end
      if (in_xfer) begin
        pos_q  <= pos_d;
        crc_q  <= crc_d;
        held_q <= held_d;
        last_q <= last_d;
        vcnt_q <= vcnt_d;
        ecnt_q <= ecnt_d;
      end
    end
  end

  // Frame bytes 2..10; header bytes are implied by the position
  always_ff @(posedge clk_i) begin
    for (int i = PosVersion; i <= PosLastCrc; i++) begin
      if (in_xfer && store_en && (pos_q == 4'(i))) frame_q[i] <= b;
    end
  end

  // Two-entry result buffer: main drives the port, skid catches a transfer during a stall
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_xfer) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_xfer) begin
      if (main_valid_q && !out_xfer) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end else if (out_xfer) begin
      main_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_xfer) main_q <= skid_q;
    end else if (in_xfer) begin
      if (main_valid_q && !out_xfer) begin
        skid_q <= res_d;
      end else begin
        main_q <= res_d;
      end
    end
  end

endmodule
